/* rtl/aps_pkg.sv */
// Shared types and constants for the aging priority shelf select block.
// No dependencies; aps_cell and aging_priority_shelf_select import this package.
package aps_pkg;

  // Shelf depth and derived widths
  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Reset value of the age limit register
  localparam logic [31:0] AGE_LIMIT_RESET = 32'd6000;

  // Request commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Response status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // One stored packet
  typedef struct packed {
    logic [15:0] id;
    logic        pri;
    logic [31:0] created;
  } aps_slot_t;

  // Per-cycle commands from the controller to every cell
  typedef struct packed {
    logic eval;
    logic insert;
    logic remove;
  } aps_cell_ctrl_t;

  // Prefix flags passed down the row of cells
  typedef struct packed {
    logic aged_seen;
    logic high_seen;
    logic pick_seen;
  } aps_chain_t;

endpackage

/* rtl/aps_if.sv */
// Request and response channel interfaces for the aging priority shelf.
// Valid/ready handshake; no package dependency.
interface aps_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] pkt_id;
  logic        pkt_priority;
  logic [31:0] now_ms;

  modport source (output valid, cmd, pkt_id, pkt_priority, now_ms, input ready);
  modport sink (input valid, cmd, pkt_id, pkt_priority, now_ms, output ready);
endinterface

interface aps_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_id;
  logic        out_priority;

  modport source (output valid, status, out_id, out_priority, input ready);
  modport sink (input valid, status, out_id, out_priority, output ready);
endinterface

/* rtl/aps_cell.sv */
// One shelf slot: holds a packet, flags it for selection and shifts from its neighbor.
// Depends on aps_pkg.
module aps_cell import aps_pkg::*; (
  input  logic           clk,
  input  aps_cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0] slot_idx,
  input  logic [CNT_W-1:0] occupancy,
  input  logic [31:0]    now_ms,
  input  logic [31:0]    age_limit_ms,
  input  logic [15:0]    wr_id,
  input  logic           wr_priority,
  input  aps_slot_t      nbr_slot,
  input  aps_chain_t     chain_in,
  input  logic           any_aged,
  input  logic           any_high,
  output aps_slot_t      slot,
  output aps_chain_t     chain_out,
  output logic           pick
);

  logic        in_use;
  logic [31:0] age;
  logic        aged;
  logic        high;
  logic        shift_en;
  logic        write_en;

  // Slot holds a live packet when its place is below the fill level
  assign in_use = CNT_W'(slot_idx) < occupancy;
  assign age    = now_ms - slot.created;

  // Latch selection flags during the evaluate cycle
  always_ff @(posedge clk) begin
    if (ctrl.eval) begin
      aged <= in_use && !slot.pri && (age >= age_limit_ms);
      high <= in_use && slot.pri;
    end
  end

  // Pick: first aged low packet, else first high packet, else the head
  always_comb begin
    pick = 1'b0;
    if (any_aged) begin
      pick = aged && !chain_in.aged_seen;
    end else if (any_high) begin
      pick = high && !chain_in.high_seen;
    end else begin
      pick = (slot_idx == '0);
    end
  end

  // Advance prefix flags to the next cell
  assign chain_out.aged_seen = chain_in.aged_seen || aged;
  assign chain_out.high_seen = chain_in.high_seen || high;
  assign chain_out.pick_seen = chain_in.pick_seen || pick;

  assign write_en = ctrl.insert && (CNT_W'(slot_idx) == occupancy);
  assign shift_en = ctrl.remove && (pick || chain_in.pick_seen);

  // Store a new packet or close the gap from the neighbor
  always_ff @(posedge clk) begin
    if (write_en) begin
      slot.id      <= wr_id;
      slot.pri     <= wr_priority;
      slot.created <= now_ms;
    end else if (shift_en) begin
      slot <= nbr_slot;
    end
  end

endmodule

/* rtl/aging_priority_shelf_select.sv */
// Aging priority shelf select: ordered packet shelf built from a row of slot cells.
// Depends on aps_pkg, aps_if and aps_cell.
//
// Usage:
//   req channel carries cmd (insert or remove), pkt_id, pkt_priority and now_ms.
//   An insert appends a packet stamped with now_ms or reports shelf full.
//   A remove takes the earliest low-priority packet whose age reached
//   age_limit_ms, else the first high-priority packet, else the head packet,
//   and later packets move up one slot; an empty shelf reports empty.
//   rsp channel returns status, out_id and out_priority, one per request.
//   cfg_we/cfg_wdata write age_limit_ms; write only while the block is idle.
// Timing:
//   After a request is accepted the block passes through ST_EVAL, where every
//   cell registers its age compare, then ST_COMMIT, where the pick resolves along
//   the cell row, the cells shift and the response is registered. One request is
//   in flight at a time; the next is accepted once the block is back in ST_IDLE.
//   A new request is accepted while the previous response waits; its commit
//   then holds until the response register is taken, so a stalled receiver
//   stalls the block without losing or repeating anything.
// Reset: the shelf is empty and age_limit_ms returns to 6000.
module aging_priority_shelf_select import aps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  aps_req_if.sink    req,
  aps_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] occupancy;
  logic [31:0]      age_limit_ms;
  logic             req_cmd;
  logic [15:0]      req_id;
  logic             req_pri;
  logic [31:0]      req_now;

  logic             commit_go;
  logic             full;
  logic             empty;
  aps_cell_ctrl_t   ctrl;

  aps_slot_t        slot_q   [SLOTS];
  aps_slot_t        nbr_slot [SLOTS];
  aps_chain_t       chain_in [SLOTS];
  aps_chain_t       chain_out[SLOTS];
  logic [SLOTS-1:0] pick_vec;
  logic             any_aged;
  logic             any_high;
  logic [15:0]      pick_id;
  logic             pick_pri;

  assign full      = (occupancy == CNT_W'(SLOTS));
  assign empty     = (occupancy == '0);
  assign commit_go = (state == ST_COMMIT) && (!rsp.valid || rsp.ready);
  assign req.ready = (state == ST_IDLE);

  // Drive cell commands
  assign ctrl.eval   = (state == ST_EVAL);
  assign ctrl.insert = commit_go && (req_cmd == CMD_INSERT) && !full;
  assign ctrl.remove = commit_go && (req_cmd == CMD_REMOVE) && !empty;

  // Row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign chain_in[i] = '0;
    end else begin : g_link
      assign chain_in[i] = chain_out[i-1];
    end
    if (i == SLOTS - 1) begin : g_tail
      assign nbr_slot[i] = slot_q[i];
    end else begin : g_nbr
      assign nbr_slot[i] = slot_q[i+1];
    end

    aps_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .slot_idx     (IDX_W'(i)),
      .occupancy    (occupancy),
      .now_ms       (req_now),
      .age_limit_ms (age_limit_ms),
      .wr_id        (req_id),
      .wr_priority  (req_pri),
      .nbr_slot     (nbr_slot[i]),
      .chain_in     (chain_in[i]),
      .any_aged     (any_aged),
      .any_high     (any_high),
      .slot         (slot_q[i]),
      .chain_out    (chain_out[i]),
      .pick         (pick_vec[i])
    );
  end

  assign any_aged = chain_out[SLOTS-1].aged_seen;
  assign any_high = chain_out[SLOTS-1].high_seen;

  // Gather the picked packet
  always_comb begin
    pick_id  = '0;
    pick_pri = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      pick_id  = pick_id | (slot_q[i].id & {16{pick_vec[i]}});
      pick_pri = pick_pri | (slot_q[i].pri & pick_vec[i]);
    end
  end

  // Hold state, fill level, configuration and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      occupancy    <= '0;
      age_limit_ms <= AGE_LIMIT_RESET;
      rsp.valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        age_limit_ms <= cfg_wdata;
      end
      // Raise the response on a commit, drop it once taken
      if (commit_go) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            req_cmd <= req.cmd;
            req_id  <= req.pkt_id;
            req_pri <= req.pkt_priority;
            req_now <= req.now_ms;
            state   <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (commit_go) begin
            if (req_cmd == CMD_INSERT) begin
              rsp.out_id       <= '0;
              rsp.out_priority <= 1'b0;
              if (full) begin
                rsp.status <= STATUS_FULL;
              end else begin
                rsp.status <= STATUS_DONE;
                occupancy  <= occupancy + CNT_W'(1);
              end
            end else if (empty) begin
              rsp.status       <= STATUS_EMPTY;
              rsp.out_id       <= '0;
              rsp.out_priority <= 1'b0;
            end else begin
              rsp.status       <= STATUS_DONE;
              rsp.out_id       <= pick_id;
              rsp.out_priority <= pick_pri;
              occupancy        <= occupancy - CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Fill level never passes the shelf depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(SLOTS))
    else $error("shelf fill level above depth");

  // A remove from a non-empty shelf picks exactly one slot
  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    ctrl.remove |-> $onehot(pick_vec))
    else $error("remove picked no slot or several slots");

  // After an accepted request the block takes no other until it commits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request accepted while one is in flight");

  // Fill level moves only at a commit
  a_occ_commit: assert property (@(posedge clk) disable iff (rst)
    !commit_go |=> $stable(occupancy))
    else $error("fill level changed outside a commit");
`endif

endmodule
